// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scan code translator check failed");

// Clocked assertion that also runs during reset.
`define SC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scan code translator reset check failed");

`endif

// ----- hdl/sc2a_pkg.sv -----
// Types, scan code constants and keymap tables for the scan code translator.
package sc2a_pkg;

    // Scan code values
    localparam logic [7:0] SC_RELEASE = 8'h80;
    localparam logic [6:0] SC_LSHIFT  = 7'h2a;
    localparam logic [6:0] SC_RSHIFT  = 7'h36;
    localparam logic [6:0] SC_ALT     = 7'h38;
    localparam logic [6:0] SC_CTL     = 7'h1d;
    localparam logic [6:0] SC_CAPS    = 7'h3a;
    localparam logic [7:0] SC_PREFIX  = 8'he0;
    localparam logic [7:0] SC_KEYMASK = 8'h7f;
    localparam logic [7:0] ALT_BIT    = 8'h80;

    localparam int PLAIN_LEN = 58;
    localparam int CTL_LEN   = 51;
    localparam int TAB_IW    = $clog2(PLAIN_LEN);

    // Modifier flags, ctl in bit 0
    typedef struct packed {
        logic ext;
        logic alt;
        logic caps;
        logic shift;
        logic ctl;
    } mod_flags_t;

    // Translation result for one word
    typedef struct packed {
        mod_flags_t flags;
        logic       char_valid;
        logic [7:0] char_code;
    } xlate_res_t;

    localparam logic [7:0] PLAIN_TAB [0:PLAIN_LEN-1] = '{
        8'h00,
        8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
        8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61,
        8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b, 8'h27,
        8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e, 8'h6d,
        8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h20
    };

    localparam logic [7:0] UPPER_TAB [0:PLAIN_LEN-1] = '{
        8'h00,
        8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28,
        8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54,
        8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41,
        8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a, 8'h22,
        8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e, 8'h4d,
        8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h00, 8'h00, 8'h20
    };

    localparam logic [7:0] CTL_TAB [0:CTL_LEN-1] = '{
        8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h1f, 8'h00, 8'h08, 8'h09, 8'h11, 8'h17, 8'h05, 8'h12, 8'h14,
        8'h19, 8'h15, 8'h09, 8'h0f, 8'h10, 8'h1b, 8'h1d, 8'h0a, 8'h00, 8'h01,
        8'h13, 8'h04, 8'h06, 8'h07, 8'h08, 8'h0a, 8'h0b, 8'h0c, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h1c, 8'h1a, 8'h18, 8'h03, 8'h16, 8'h02, 8'h0e, 8'h0d
    };

    // Flag mask of a modifier key, zero for other keys
    function automatic mod_flags_t modifier_bit(input logic [6:0] key);
        mod_flags_t m;
        m = '0;
        case (key)
            SC_LSHIFT, SC_RSHIFT: m.shift = 1'b1;
            SC_CAPS:              m.caps  = 1'b1;
            SC_CTL:               m.ctl   = 1'b1;
            SC_ALT:               m.alt   = 1'b1;
            default:              m = '0;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/sc2a_xlate.sv -----
// Combinational translation of one scan code with modifier flag update.
module sc2a_xlate (
    input  logic [7:0]          code,
    input  sc2a_pkg::mod_flags_t flags,
    output sc2a_pkg::xlate_res_t res
);
    import sc2a_pkg::*;

    mod_flags_t     mask;
    logic [TAB_IW-1:0] idx;
    logic           in_plain;
    logic           in_ctl;
    logic           upper;

    assign mask     = modifier_bit(code[6:0]);
    assign idx      = code[TAB_IW-1:0];
    assign in_plain = (code < 8'(PLAIN_LEN));
    assign in_ctl   = (code < 8'(CTL_LEN));
    assign upper    = flags.shift ^ flags.caps;

    // Priority: pending prefix, prefix, release, modifier press, lookup
    always_comb
    begin
        res.flags      = flags;
        res.char_valid = 1'b0;
        res.char_code  = '0;
        if (flags.ext)
        begin
            res.flags.ext = 1'b0;
        end
        else if (code == SC_PREFIX)
        begin
            res.flags.ext = 1'b1;
        end
        else if ((code & SC_RELEASE) != '0)
        begin
            res.flags = flags & ~mask;
        end
        else if (mask != '0)
        begin
            res.flags = flags | mask;
        end
        else
        begin
            if (flags.ctl)
            begin
                if (in_ctl)
                begin
                    res.char_valid = 1'b1;
                    res.char_code  = CTL_TAB[idx];
                end
            end
            else if (in_plain)
            begin
                res.char_valid = 1'b1;
                res.char_code  = upper ? UPPER_TAB[idx] : PLAIN_TAB[idx];
            end
            if (res.char_valid && flags.alt)
            begin
                res.char_code = res.char_code + ALT_BIT;
            end
        end
    end

endmodule

// ----- hdl/scan_code_to_ascii_core.sv -----
// An accepted input word passes through the input and output registers to its result.
// Throughput: one word per cycle unless the output stalls; the input register feeds the
// table lookup and flag update, whose result lands in the output register.
// Output stall holds both registers; input stays ready while the output is free.
// Reset (rst_n low, asynchronous) empties both stages and clears all modifier flags.
module scan_code_to_ascii_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] char_code
    output logic       m_axis_tuser    // [0] char_valid
);
    import sc2a_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_code_reg;
    mod_flags_t flags_reg;
    logic       out_valid_reg;
    logic [7:0] out_code_reg;
    logic       out_char_reg;
    logic       advance;
    xlate_res_t res;

    // Stage advances when the output is empty or being taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    sc2a_xlate u_xlate (
        .code  (in_code_reg),
        .flags (flags_reg),
        .res   (res)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
                flags_reg <= res.flags;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_code_reg <= s_axis_tdata;
        if (advance && in_valid_reg)
        begin
            out_code_reg <= res.char_code;
            out_char_reg <= res.char_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tuser  = out_char_reg;

endmodule

// ----- hdl/sc2a_chk.sv -----
// Port-level checker for the scan code translator, bound to the top level.
`include "assert_macros.svh"

module sc2a_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // Stalled result word holds
    `SC_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A free output always lets the input side move
    `SC_ASSERT(a_in_ready, clk, rst_n, m_axis_tready |-> s_axis_tready)

    // An accepted word shows up on the output after the input and output registers
    `SC_ASSERT(a_in_to_out, clk, rst_n, s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)

    // No character means a zero code
    `SC_ASSERT(a_nochar_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'h00)

    // Reset empties the output
    `SC_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !m_axis_tvalid)

endmodule

bind scan_code_to_ascii_core sc2a_chk u_sc2a_chk (.*);
